FILE: rtl/gcs_pkg.sv
// Shared constants for the grayscale contrast stretch block.
// Register indexes, sideband bit positions and default sizes; no dependencies.
`default_nettype none

package gcs_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEW_MIN  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEW_MAX  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CODE = 2'd2;

  localparam int S_TUSER_BITS      = 2;
  localparam int TUSER_REQ_TYPE    = 0;
  localparam int TUSER_FRAME_START = 1;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_SCALE   = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/grayscale_contrast_stretch.sv
// Min/max contrast stretch of grey pixels; top level.
// Measure words: taken one per cycle while the queue has room, no result.
// Scale words: multiplied, then divided by the bit-serial divider (skipped when flat);
// the back end takes the next queued scale word only once the last result is registered.
// Reset (synchronous, active high) restores registers, range and empties queue.
// Depends on gcs_pkg, gcs_regs, gcs_front, gcs_queue, gcs_back.
`default_nettype none

module grayscale_contrast_stretch #(
  parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pixel
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]    s_tdata,
  // req_type, frame_start
  input  logic [gcs_pkg::S_TUSER_BITS-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // scaled_pixel
  output logic [((PIXEL_BITS+7)/8)*8-1:0]    m_tdata,
  // flat_range
  output logic                               m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [PIXEL_BITS-1:0]              cfg_data
);
  import gcs_pkg::*;

  localparam int DATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int ENTRY_W = 3 * PIXEL_BITS + 1;

  logic [PIXEL_BITS-1:0] new_min;
  logic [PIXEL_BITS-1:0] new_max;
  logic [PIXEL_BITS-1:0] max_code;
  logic                  push;
  logic [ENTRY_W-1:0]    push_data;
  logic                  queue_full;
  logic                  pop;
  logic                  not_empty;
  logic [ENTRY_W-1:0]    head;

  gcs_regs #(.PIXEL_BITS(PIXEL_BITS)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .new_min   (new_min),
    .new_max   (new_max),
    .max_code  (max_code)
  );

  gcs_front #(.PIXEL_BITS(PIXEL_BITS), .DATA_W(DATA_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .max_code   (max_code),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  gcs_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  gcs_back #(.PIXEL_BITS(PIXEL_BITS), .DATA_W(DATA_W)) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (not_empty),
    .pop         (pop),
    .entry       (head),
    .new_min     (new_min),
    .new_max     (new_max),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/gcs_regs.sv
// Configuration registers: new_min, new_max and max_code.
// Depends on gcs_pkg for register indexes.
`default_nettype none

module gcs_regs #(
  parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [PIXEL_BITS-1:0]             cfg_data,
  output logic [PIXEL_BITS-1:0]             new_min,
  output logic [PIXEL_BITS-1:0]             new_max,
  output logic [PIXEL_BITS-1:0]             max_code
);
  import gcs_pkg::*;

  localparam logic [PIXEL_BITS-1:0] RESET_HI = PIXEL_BITS'(8'hFF);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_min  <= '0;
      new_max  <= RESET_HI;
      max_code <= RESET_HI;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEW_MIN:  new_min  <= cfg_data;
        REG_NEW_MAX:  new_max  <= cfg_data;
        REG_MAX_CODE: max_code <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcs_front.sv
// Front end: accepts input words, folds measure pixels into running min/max
// and queues scale pixels with a snapshot of the range. Depends on gcs_pkg.
`default_nettype none

module gcs_front #(
  parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF,
  parameter int DATA_W     = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [DATA_W-1:0]                  s_tdata,
  input  logic [gcs_pkg::S_TUSER_BITS-1:0]   s_tuser,
  input  logic [PIXEL_BITS-1:0]              max_code,
  output logic                               push,
  output logic [3*PIXEL_BITS:0]              push_data,
  input  logic                               queue_full
);
  import gcs_pkg::*;

  localparam logic [PIXEL_BITS-1:0] RESET_HI = PIXEL_BITS'(8'hFF);

  logic [PIXEL_BITS-1:0] running_min;
  logic [PIXEL_BITS-1:0] running_max;
  logic [PIXEL_BITS-1:0] min_base;
  logic [PIXEL_BITS-1:0] max_base;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  accept;
  logic                  flat;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign pixel    = s_tdata[PIXEL_BITS-1:0];
  assign flat     = running_max <= running_min;

  assign push      = accept && (s_tuser[TUSER_REQ_TYPE] == REQ_SCALE);
  assign push_data = {flat, running_max, running_min, pixel};

  always_comb begin
    min_base = running_min;
    max_base = running_max;
    if (s_tuser[TUSER_FRAME_START]) begin
      min_base = max_code;
      max_base = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= RESET_HI;
      running_max <= '0;
    end else if (accept && (s_tuser[TUSER_REQ_TYPE] == REQ_MEASURE)) begin
      running_min <= (pixel < min_base) ? pixel : min_base;
      running_max <= (pixel > max_base) ? pixel : max_base;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcs_queue.sv
// Short FIFO between front and back ends.
// Takes its default depth from gcs_pkg; depth must be a power of two.
`default_nettype none

module gcs_queue #(
  parameter int WIDTH = 25,
  parameter int DEPTH = gcs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import gcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcs_back.sv
// Back end: multiply, bit-serial restoring divide and output register.
// Depends on gcs_pkg; takes entries from gcs_queue.
`default_nettype none

module gcs_back #(
  parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF,
  parameter int DATA_W     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  entry_valid,
  output logic                  pop,
  input  logic [3*PIXEL_BITS:0] entry,
  input  logic [PIXEL_BITS-1:0] new_min,
  input  logic [PIXEL_BITS-1:0] new_max,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,
  output logic                  m_tuser
);
  import gcs_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int NUM_W = 2 * PB + 2;
  localparam int MAG_W = 2 * PB + 1;
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                 state;
  logic [PB-1:0]          e_pixel;
  logic [PB-1:0]          e_min;
  logic [PB-1:0]          divisor;
  logic                   flat;
  logic signed [NUM_W-1:0] prod;
  logic                   neg;
  logic [MAG_W-1:0]       mag;
  logic [PB:0]            rem;
  logic [PB-1:0]          quot;
  logic [CNT_W-1:0]       cnt;
  logic [PB-1:0]          out_pix;

  logic signed [PB:0]     diff;
  logic signed [PB:0]     span_out;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]       num_abs;
  logic [PB:0]            rem_sh;
  logic                   ge;
  logic [PB:0]            quot_sh;
  logic [PB-1:0]          quot_signed;
  logic                   out_free;

  assign pop      = (state == ST_IDLE) && entry_valid;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = DATA_W'(out_pix);

  always_comb begin
    diff        = $signed({1'b0, e_pixel}) - $signed({1'b0, e_min});
    span_out    = $signed({1'b0, new_max}) - $signed({1'b0, new_min});
    num         = prod + $signed({{(PB + 2){1'b0}}, divisor >> 1});
    num_abs     = num[NUM_W-1] ? -num : num;
    rem_sh      = {rem[PB-1:0], mag[MAG_W-1]};
    ge          = rem_sh >= {1'b0, divisor};
    quot_sh     = {quot, ge};
    quot_signed = neg ? -quot : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (entry_valid) begin
            e_pixel <= entry[PB-1:0];
            e_min   <= entry[2*PB-1:PB];
            divisor <= entry[3*PB-1:2*PB] - entry[2*PB-1:PB];
            flat    <= entry[3*PB];
            state   <= entry[3*PB] ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= diff * span_out;
          state <= ST_ABS;
        end
        ST_ABS: begin
          neg   <= num[NUM_W-1];
          mag   <= num_abs[MAG_W-1:0];
          rem   <= '0;
          quot  <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem   <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
          mag   <= mag << 1;
          quot  <= quot_sh[PB-1:0];
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAG_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_pix  <= flat ? new_min : quot_signed + new_min;
            m_tuser  <= flat;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcs_checker.sv
// Port-level checks for grayscale_contrast_stretch, bound to the top level.
// Depends on gcs_pkg and the top-level port list.
`default_nettype none

module gcs_checker #(
  parameter int PIXEL_BITS = gcs_pkg::PIXEL_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [gcs_pkg::S_TUSER_BITS-1:0]   s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [((PIXEL_BITS+7)/8)*8-1:0]    m_tdata,
  input logic                               m_tuser,
  input logic                               cfg_ready
);
  import gcs_pkg::*;

  logic [7:0] pending;
  logic       scale_in;
  logic       word_out;

  assign scale_in = s_tvalid && s_tready && (s_tuser[TUSER_REQ_TYPE] == REQ_SCALE);
  assign word_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, scale_in} - {7'd0, word_out};
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> pending != 8'd0)
    else $error("output word without a pending scale word");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind grayscale_contrast_stretch gcs_checker #(.PIXEL_BITS(PIXEL_BITS)) u_gcs_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: tb/sv/grayscale_contrast_stretch_tb.sv
// Testbench for grayscale_contrast_stretch: measure and scale words with random idling.
// An internal predictor checks every result. Depends on gcs_pkg and the RTL top level.
`default_nettype none

module grayscale_contrast_stretch_tb;
  import gcs_pkg::*;

  localparam int PB           = 8;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [PB-1:0] pixel;
    logic          flat;
  } stretch_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [PB-1:0]           s_tdata = '0;
  logic [S_TUSER_BITS-1:0] s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [PB-1:0]           m_tdata;
  logic                    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [PB-1:0]           cfg_data = '0;

  grayscale_contrast_stretch i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  logic [PB-1:0] out_min  = 8'd0;
  logic [PB-1:0] out_max  = 8'd255;
  logic [PB-1:0] code_max = 8'd255;
  logic [PB-1:0] range_min = 8'd255;
  logic [PB-1:0] range_max = 8'd0;

  stretch_t pending_stretch[$];
  int errors    = 0;
  int n_measure = 0;
  int n_scale   = 0;
  int n_results = 0;
  int n_flat    = 0;
  int n_writes  = 0;
  bit tx_idle   = 1'b0;
  bit rx_idle   = 1'b0;
  bit hold_req  = 1'b0;
  int stall_cnt = 0;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic stretch_t predict_stretch(logic [PB-1:0] pix);
    longint lo, hi, p, nlo, nhi, span_in, num, val;
    stretch_t r;
    lo  = range_min;
    hi  = range_max;
    p   = pix;
    nlo = out_min;
    nhi = out_max;
    if (hi <= lo) begin
      r.pixel = out_min;
      r.flat  = 1'b1;
    end else begin
      span_in = hi - lo;
      num     = (p - lo) * (nhi - nlo) + span_in / 2;
      val     = num / span_in + nlo;
      r.pixel = val[PB-1:0];
      r.flat  = 1'b0;
    end
    return r;
  endfunction

  task automatic fold_measure(input logic [PB-1:0] pix, input logic restart);
    if (restart) begin
      range_min = code_max;
      range_max = '0;
    end
    if (pix < range_min) range_min = pix;
    if (pix > range_max) range_max = pix;
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_pixel(input logic kind, input logic [PB-1:0] pix, input logic restart);
    logic [S_TUSER_BITS-1:0] u;
    u = '0;
    u[TUSER_REQ_TYPE]    = kind;
    u[TUSER_FRAME_START] = restart;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= u;
    do @(posedge clk); while (!s_tready);
    if (kind == REQ_SCALE) begin
      pending_stretch.push_back(predict_stretch(pix));
      n_scale++;
    end else begin
      fold_measure(pix, restart);
      n_measure++;
    end
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_stretch.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [PB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NEW_MIN:  out_min  = val;
      REG_NEW_MAX:  out_max  = val;
      REG_MAX_CODE: code_max = val;
      default: ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mapping(input logic [PB-1:0] lo, input logic [PB-1:0] hi,
                             input logic [PB-1:0] code);
    drain();
    write_reg(REG_NEW_MIN, lo);
    write_reg(REG_NEW_MAX, hi);
    write_reg(REG_MAX_CODE, code);
  endtask

  task automatic run_frame(input int n_meas, input int n_out);
    int lo, hi, a, b;
    a  = $urandom_range(0, 255);
    b  = ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, 255);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    send_pixel(REQ_MEASURE, PB'($urandom_range(lo, hi)), 1'b1);
    for (int i = 1; i < n_meas; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_pixel(REQ_MEASURE, PB'($urandom), 1'($urandom_range(0, 1)));
      else
        send_pixel(REQ_MEASURE, PB'($urandom_range(lo, hi)), 1'b0);
    end
    for (int i = 0; i < n_out; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(REQ_SCALE, PB'($urandom), 1'($urandom_range(0, 1)));
      else
        send_pixel(REQ_SCALE, PB'($urandom_range(lo, hi)), 1'b0);
    end
  endtask

  task automatic test_directed_cases();
    send_pixel(REQ_SCALE, 8'd77, 1'b0);
    send_pixel(REQ_SCALE, 8'd255, 1'b1);
    send_pixel(REQ_MEASURE, 8'd100, 1'b1);
    send_pixel(REQ_SCALE, 8'd100, 1'b0);
    send_pixel(REQ_MEASURE, 8'd0, 1'b0);
    send_pixel(REQ_MEASURE, 8'd255, 1'b0);
    send_pixel(REQ_SCALE, 8'd0, 1'b0);
    send_pixel(REQ_SCALE, 8'd255, 1'b0);
    send_pixel(REQ_SCALE, 8'd128, 1'b0);
    send_pixel(REQ_MEASURE, 8'd10, 1'b1);
    send_pixel(REQ_MEASURE, 8'd20, 1'b0);
    send_pixel(REQ_SCALE, 8'd0, 1'b0);
    send_pixel(REQ_SCALE, 8'd255, 1'b0);
    set_mapping(8'd200, 8'd30, 8'd255);
    send_pixel(REQ_SCALE, 8'd15, 1'b0);
    send_pixel(REQ_SCALE, 8'd10, 1'b0);
    send_pixel(REQ_SCALE, 8'd20, 1'b0);
    set_mapping(8'd0, 8'd255, 8'd100);
    send_pixel(REQ_MEASURE, 8'd200, 1'b1);
    send_pixel(REQ_SCALE, 8'd150, 1'b0);
    send_pixel(REQ_SCALE, 8'd100, 1'b0);
    set_mapping(8'd0, 8'd255, 8'd1);
    send_pixel(REQ_MEASURE, 8'd1, 1'b1);
    send_pixel(REQ_SCALE, 8'd1, 1'b0);
    drain();
  endtask

  task automatic test_register_sweep();
    logic [PB-1:0] sweep[6][3];
    sweep = '{'{8'd255, 8'd0, 8'd1}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd1},
              '{8'd50, 8'd200, 8'd128}, '{8'd0, 8'd255, 8'd255}, '{8'd128, 8'd127, 8'd200}};
    for (int k = 0; k < 6; k++) begin
      set_mapping(sweep[k][0], sweep[k][1], sweep[k][2]);
      tx_idle = k[0];
      rx_idle = k[1];
      run_frame($urandom_range(1, 6), $urandom_range(2, 5));
    end
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    send_pixel(REQ_MEASURE, 8'd30, 1'b1);
    send_pixel(REQ_MEASURE, 8'd220, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_pixel(REQ_SCALE, PB'($urandom), 1'b0);
    for (int i = 0; i < 8; i++) send_pixel(REQ_MEASURE, PB'($urandom_range(30, 220)), 1'b0);
    drain();
  endtask

  task automatic test_random_frames();
    int start;
    int n_frames;
    start    = n_measure + n_scale;
    n_frames = 0;
    while (n_measure + n_scale - start < RANDOM_ITEMS) begin
      if (n_frames % 8 == 7) begin
        if ($urandom_range(0, 2) == 0)
          set_mapping($urandom_range(0, 1) ? 8'd255 : 8'd0,
                      $urandom_range(0, 1) ? 8'd255 : 8'd0,
                      $urandom_range(0, 1) ? 8'd255 : 8'd1);
        else
          set_mapping(PB'($urandom), PB'($urandom), PB'($urandom_range(1, 255)));
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      run_frame($urandom_range(1, 20), $urandom_range(1, 10));
      n_frames++;
    end
    drain();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_len() - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    stretch_t exp_word;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser) n_flat++;
      if (pending_stretch.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%0d flat=%0d", m_tdata, m_tuser));
      end else begin
        exp_word = pending_stretch.pop_front();
        if (m_tdata !== exp_word.pixel)
          report_mismatch($sformatf("scaled_pixel got %0d want %0d", m_tdata, exp_word.pixel));
        if (m_tuser !== exp_word.flat)
          report_mismatch($sformatf("flat_range got %0d want %0d", m_tuser, exp_word.flat));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_stretch.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_sweep();
    test_backpressure();
    test_random_frames();
    drain();
    if (pending_stretch.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_stretch.size()));
    $display("covered %0d measure and %0d scale words, %0d results (%0d flat), %0d reg writes",
             n_measure, n_scale, n_results, n_flat, n_writes);
    $display("mapping extremes, inverted output range and a long output hold-off included");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/gcs_pkg.sv
rtl/gcs_regs.sv
rtl/gcs_front.sv
rtl/gcs_queue.sv
rtl/gcs_back.sv
rtl/grayscale_contrast_stretch.sv
rtl/gcs_checker.sv
tb/sv/grayscale_contrast_stretch_tb.sv
